// ===== rtl/cddi_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cddi_pkg
// Shared constants, types and helper functions for the disc ID generator.
// ============================================================================
package cddi_pkg;

    // track limit and field widths
    localparam int MAX_TRACK_COUNT = 99;
    localparam int MIN_W           = 7;
    localparam int SEC_W           = 6;
    localparam int TIME_W          = 13;
    localparam int DIG_W           = 7;
    localparam int DSUM7_W         = 5;
    localparam int DSUM_W          = 6;
    localparam int DTOTAL_W        = 12;
    localparam int TRACK_W         = 7;
    localparam int ID_W            = 32;
    localparam int CSUM_W          = 8;
    localparam int PLAY_W          = 16;
    localparam int COUNT_W         = 8;

    // checksum folding modulus
    localparam int CSUM_MOD        = 255;

    // reciprocal of 100, exact floor for any 13-bit value
    localparam int RECIP_W         = 14;
    localparam int RECIP_SHIFT     = 19;
    localparam int PROD_W          = 26;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    // classified track item handed from front to back
    typedef struct packed {
        logic [DSUM_W-1:0] digit_sum;
        logic [TIME_W-1:0] start_total;
        logic [TIME_W-1:0] length_total;
        logic              last;
    } track_item_t;

    // minutes and seconds to total seconds (min * 60 as two shifts)
    function automatic logic [TIME_W-1:0] to_seconds(
        input logic [MIN_W-1:0] mins,
        input logic [SEC_W-1:0] secs
    );
        logic [TIME_W-1:0] mw;
        mw = TIME_W'(mins);
        return (mw << 6) - (mw << 2) + TIME_W'(secs);
    endfunction

    // decimal digit sum of a value below 100: v - 9 * floor(v / 10)
    function automatic logic [DSUM7_W-1:0] digit_sum7(input logic [DIG_W-1:0] v);
        logic [3:0]       tens;
        logic [DIG_W-1:0] nine_tens;
        tens = '0;
        for (int k = 1; k <= 12; k++)
        begin
            if (v >= DIG_W'(10 * k))
            begin
                tens = tens + 4'd1;
            end
        end
        nine_tens = DIG_W'({tens, 3'b000}) + DIG_W'(tens);
        return DSUM7_W'(v - nine_tens);
    endfunction

endpackage

// ===== rtl/cd_disc_id_generator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cd_disc_id_generator
// Disc ID generator: builds the 32-bit table-of-contents ID track by track.
// ============================================================================
// Usage:
//   Input channel (push/full): one item per track, start minutes and seconds,
//   with last_track set on the final track together with the disc length.
//   Result channel (empty/pop): one item per disc, holding disc_id, the
//   track count and the overflow flag; it shows while empty is low.
//   Throughput: one track item per cycle while full stays low.
//   Path: a last-track item is loaded into the first front stage at the
//   accepting edge, then passes two more front stages (hundreds split, digit
//   sum), the item queue, then the accumulator's result register.
//   Tracks past the 99th are not counted and set track_overflow.
//   Reset clears all per-disc state, the pipeline and the queue; empty is high.
//   A stalled result blocks the queue only once a last-track item reaches its
//   head; earlier tracks keep flowing, later ones back up until the queue and
//   front stages fill, then full rises.
// ============================================================================
module cd_disc_id_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [6:0]  start_minutes,
    input  logic [5:0]  start_seconds,
    input  logic        last_track,
    input  logic [6:0]  length_minutes,
    input  logic [5:0]  length_seconds,
    input  logic        pop,
    output logic        empty,
    output logic [31:0] disc_id,
    output logic [6:0]  track_total,
    output logic        track_overflow
);
    import cddi_pkg::*;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    track_item_t q_wr_item;
    track_item_t q_rd_item;

    // front end: conversion and digit sum
    cddi_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .start_minutes  (start_minutes),
        .start_seconds  (start_seconds),
        .last_track     (last_track),
        .length_minutes (length_minutes),
        .length_seconds (length_seconds),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_item         (q_wr_item)
    );

    // decoupling queue
    cddi_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (q_wr_item),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .q_empty (q_empty)
    );

    // back end: accumulation and id packing
    cddi_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_item         (q_rd_item),
        .q_pop          (q_pop),
        .pop            (pop),
        .empty          (empty),
        .disc_id        (disc_id),
        .track_total    (track_total),
        .track_overflow (track_overflow)
    );

endmodule

// ===== rtl/cddi_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cddi_front
// Three-stage elastic front end: converts each track to seconds, splits the
// start into hundreds and remainder, and forms its decimal digit sum.
// ============================================================================
module cddi_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [6:0]                start_minutes,
    input  logic [5:0]                start_seconds,
    input  logic                      last_track,
    input  logic [6:0]                length_minutes,
    input  logic [5:0]                length_seconds,
    input  logic                      q_full,
    output logic                      q_push,
    output cddi_pkg::track_item_t     q_item
);
    import cddi_pkg::*;

    logic              s1_valid_reg;
    logic [TIME_W-1:0] s1_start_reg;
    logic [TIME_W-1:0] s1_length_reg;
    logic              s1_last_reg;

    logic              s2_valid_reg;
    logic [DIG_W-1:0]  s2_hund_reg;
    logic [DIG_W-1:0]  s2_rem_reg;
    logic [TIME_W-1:0] s2_start_reg;
    logic [TIME_W-1:0] s2_length_reg;
    logic              s2_last_reg;

    logic              s3_valid_reg;
    track_item_t       s3_item_reg;

    logic              s1_ready;
    logic              s2_ready;
    logic              s3_ready;
    logic              accept;

    logic [PROD_W-1:0] prod;
    logic [DIG_W-1:0]  s2_hund_next;
    logic [TIME_W-1:0] hund_x100;
    logic [DIG_W-1:0]  s2_rem_next;
    track_item_t       s3_item_next;

    // backpressure chain, each stage moves when the next one frees up
    assign s3_ready = !s3_valid_reg || !q_full;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign full     = !s1_ready;
    assign accept   = push && s1_ready;
    assign q_push   = s3_valid_reg && !q_full;
    assign q_item   = s3_item_reg;

    // hundreds and remainder of the start seconds
    always_comb
    begin
        prod         = PROD_W'(s1_start_reg) * PROD_W'(RECIP_100);
        s2_hund_next = prod[RECIP_SHIFT +: DIG_W];
        hund_x100    = (TIME_W'(s2_hund_next) << 6) + (TIME_W'(s2_hund_next) << 5)
                     + (TIME_W'(s2_hund_next) << 2);
        s2_rem_next  = DIG_W'(s1_start_reg - hund_x100);
    end

    // digit sum from the two halves
    always_comb
    begin
        s3_item_next.digit_sum    = DSUM_W'(digit_sum7(s2_hund_reg))
                                  + DSUM_W'(digit_sum7(s2_rem_reg));
        s3_item_next.start_total  = s2_start_reg;
        s3_item_next.length_total = s2_length_reg;
        s3_item_next.last         = s2_last_reg;
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= push;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_start_reg  <= to_seconds(start_minutes, start_seconds);
            s1_length_reg <= to_seconds(length_minutes, length_seconds);
            s1_last_reg   <= last_track;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_hund_reg   <= s2_hund_next;
            s2_rem_reg    <= s2_rem_next;
            s2_start_reg  <= s1_start_reg;
            s2_length_reg <= s1_length_reg;
            s2_last_reg   <= s1_last_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_item_reg   <= s3_item_next;
        end
    end

endmodule

// ===== rtl/cddi_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cddi_queue
// Short first-in first-out queue of classified track items.
// ============================================================================
module cddi_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  cddi_pkg::track_item_t     wr_item,
    output logic                      q_full,
    input  logic                      rd_en,
    output cddi_pkg::track_item_t     rd_item,
    output logic                      q_empty
);
    import cddi_pkg::*;

    track_item_t       slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic              do_wr;
    logic              do_rd;

    assign q_full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_item = slot_reg[rd_ptr_reg];

    // pointer wrap
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== rtl/cddi_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cddi_back
// Per-disc accumulator: sums digit totals, counts tracks, keeps the first
// start and packs the disc ID into the result register on the last track.
// ============================================================================
module cddi_back
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  cddi_pkg::track_item_t     q_item,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [31:0]               disc_id,
    output logic [6:0]                track_total,
    output logic                      track_overflow
);
    import cddi_pkg::*;

    logic [DTOTAL_W-1:0] digit_total_reg;
    logic [TRACK_W-1:0]  tracks_seen_reg;
    logic [TIME_W-1:0]   first_start_reg;
    logic                overflow_seen_reg;

    logic                out_valid_reg;
    logic [ID_W-1:0]     disc_id_reg;
    logic [TRACK_W-1:0]  track_total_reg;
    logic                track_overflow_reg;

    logic                take;
    logic                under_max;
    logic [DTOTAL_W-1:0] digit_total_next;
    logic [TRACK_W-1:0]  tracks_seen_next;
    logic [TIME_W-1:0]   first_start_next;
    logic                overflow_seen_next;
    logic [CSUM_W:0]     fold;
    logic [CSUM_W-1:0]   csum;
    logic [TIME_W-1:0]   playing;
    logic [ID_W-1:0]     disc_id_next;

    // a non-final track never waits on the result register
    assign take  = !q_empty && (!q_item.last || !out_valid_reg || pop);
    assign q_pop = take;

    assign empty          = !out_valid_reg;
    assign disc_id        = disc_id_reg;
    assign track_total    = track_total_reg;
    assign track_overflow = track_overflow_reg;

    // running totals with this track folded in
    always_comb
    begin
        under_max = (tracks_seen_reg < TRACK_W'(MAX_TRACK_COUNT));
        if (under_max)
        begin
            digit_total_next   = digit_total_reg + DTOTAL_W'(q_item.digit_sum);
            tracks_seen_next   = tracks_seen_reg + 1'b1;
            first_start_next   = (tracks_seen_reg == '0) ? q_item.start_total
                                                         : first_start_reg;
            overflow_seen_next = overflow_seen_reg;
        end
        else
        begin
            digit_total_next   = digit_total_reg;
            tracks_seen_next   = tracks_seen_reg;
            first_start_next   = first_start_reg;
            overflow_seen_next = 1'b1;
        end
    end

    // checksum mod 255 by folding the high nibble onto the low byte
    always_comb
    begin
        fold = (CSUM_W + 1)'(digit_total_next[DTOTAL_W-1:CSUM_W])
             + (CSUM_W + 1)'(digit_total_next[CSUM_W-1:0]);
        if (fold >= (CSUM_W + 1)'(CSUM_MOD))
        begin
            csum = CSUM_W'(fold - (CSUM_W + 1)'(CSUM_MOD));
        end
        else
        begin
            csum = fold[CSUM_W-1:0];
        end
    end

    // playing time, clamped at zero, and id packing
    always_comb
    begin
        if (q_item.length_total > first_start_next)
        begin
            playing = q_item.length_total - first_start_next;
        end
        else
        begin
            playing = '0;
        end
        disc_id_next = {csum, PLAY_W'(playing), COUNT_W'(tracks_seen_next)};
    end

    // per-disc state, cleared after the last track
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_total_reg   <= '0;
            tracks_seen_reg   <= '0;
            first_start_reg   <= '0;
            overflow_seen_reg <= 1'b0;
        end
        else if (take)
        begin
            if (q_item.last)
            begin
                digit_total_reg   <= '0;
                tracks_seen_reg   <= '0;
                first_start_reg   <= '0;
                overflow_seen_reg <= 1'b0;
            end
            else
            begin
                digit_total_reg   <= digit_total_next;
                tracks_seen_reg   <= tracks_seen_next;
                first_start_reg   <= first_start_next;
                overflow_seen_reg <= overflow_seen_next;
            end
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && q_item.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (take && q_item.last)
        begin
            disc_id_reg        <= disc_id_next;
            track_total_reg    <= tracks_seen_next;
            track_overflow_reg <= overflow_seen_next;
        end
    end

endmodule

// ===== rtl/cddi_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cddi_checker
// Port-level checks on the disc ID generator's result channel.
// ============================================================================
module cddi_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pop,
    input  logic        empty,
    input  logic [31:0] disc_id,
    input  logic [6:0]  track_total,
    input  logic        track_overflow
);
    import cddi_pkg::*;

    // a waiting result holds until it is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(disc_id))
        else $error("result changed while stalled");

    // count byte of the id matches the track count
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> disc_id[7:0] == {1'b0, track_total})
        else $error("id count byte differs from track_total");

    // overflow only once the track limit was reached
    a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && track_overflow |-> track_total == TRACK_W'(MAX_TRACK_COUNT))
        else $error("overflow flagged below the track limit");

    // checksum byte is reduced mod 255
    a_csum: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> disc_id[31:24] != 8'hFF)
        else $error("checksum byte not reduced");

    // nothing to deliver right after reset
    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty)
        else $error("result present after reset");

endmodule

bind cd_disc_id_generator cddi_checker u_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the disc ID generator: a directed table of discs,
// then random discs of random length, predicted track by track and checked
// field by field against the result queue under random push and pop idling.
// ============================================================================
module tb_top;

    import cddi_pkg::*;

    // one track item as offered on the input side, with an optional fixed result
    typedef struct packed {
        logic [MIN_W-1:0] smin;
        logic [SEC_W-1:0] ssec;
        logic             last;
        logic [MIN_W-1:0] lmin;
        logic [SEC_W-1:0] lsec;
        logic             fixed;
        logic [ID_W-1:0]  id;
        logic [TRACK_W-1:0] total;
        logic             ovf;
    } toc_entry_t;

    // directed table row: a track repeated reps times
    typedef struct packed {
        logic [MIN_W-1:0] smin;
        logic [SEC_W-1:0] ssec;
        logic             last;
        logic [MIN_W-1:0] lmin;
        logic [SEC_W-1:0] lsec;
        int unsigned      reps;
        logic             fixed;
        logic [ID_W-1:0]  id;
        logic [TRACK_W-1:0] total;
        logic             ovf;
    } toc_row_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TRACK_W-1:0] total;
        logic               ovf;
    } disc_result_t;

    localparam int N_ROWS       = 13;
    localparam int RANDOM_ITEMS = 1750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 20;

    // directed discs; fixed results follow from the digit sums by hand
    localparam toc_row_t DIRECTED [N_ROWS] = '{
        // all zero, single track
        '{7'd0,   6'd0,  1'b1, 7'd0,   6'd0,  1,  1'b1, 32'h0000_0001, 7'd1,  1'b0},
        // every field at full width
        '{7'd127, 6'd63, 1'b1, 7'd127, 6'd63, 1,  1'b1, 32'h1800_0001, 7'd1,  1'b0},
        // longest playing time
        '{7'd0,   6'd0,  1'b1, 7'd127, 6'd63, 1,  1'b1, 32'h001E_0301, 7'd1,  1'b0},
        // length before first start clamps to zero
        '{7'd99,  6'd59, 1'b1, 7'd0,   6'd0,  1,  1'b1, 32'h2000_0001, 7'd1,  1'b0},
        // length equal to first start
        '{7'd45,  6'd30, 1'b1, 7'd45,  6'd30, 1,  1'b1, 32'h0C00_0001, 7'd1,  1'b0},
        // two tracks, length ignored on the first
        '{7'd0,   6'd2,  1'b0, 7'd127, 6'd63, 1,  1'b0, 32'h0,         7'd0,  1'b0},
        '{7'd1,   6'd0,  1'b1, 7'd10,  6'd0,  1,  1'b1, 32'h0802_5602, 7'd2,  1'b0},
        // digit total of exactly 255 folds to a zero checksum
        '{7'd127, 6'd63, 1'b0, 7'd0,   6'd0,  10, 1'b0, 32'h0,         7'd0,  1'b0},
        '{7'd1,   6'd36, 1'b1, 7'd127, 6'd63, 1,  1'b1, 32'h0000_000B, 7'd11, 1'b0},
        // alternating bit patterns, above-range values
        '{7'd85,  6'd42, 1'b0, 7'd42,  6'd21, 1,  1'b0, 32'h0,         7'd0,  1'b0},
        '{7'd42,  6'd21, 1'b0, 7'd85,  6'd42, 1,  1'b0, 32'h0,         7'd0,  1'b0},
        '{7'd120, 6'd62, 1'b0, 7'd64,  6'd32, 1,  1'b0, 32'h0,         7'd0,  1'b0},
        '{7'd3,   6'd7,  1'b1, 7'd99,  6'd59, 1,  1'b0, 32'h0,         7'd0,  1'b0}
    };

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               push           = 1'b0;
    logic               full;
    logic [MIN_W-1:0]   start_minutes  = '0;
    logic [SEC_W-1:0]   start_seconds  = '0;
    logic               last_track     = 1'b0;
    logic [MIN_W-1:0]   length_minutes = '0;
    logic [SEC_W-1:0]   length_seconds = '0;
    logic               pop            = 1'b0;
    logic               empty;
    logic [ID_W-1:0]    disc_id;
    logic [TRACK_W-1:0] track_total;
    logic               track_overflow;

    // predictor state for the disc in progress
    int unsigned        acc_digits = 0;
    int unsigned        acc_tracks = 0;
    int unsigned        acc_first  = 0;
    logic               acc_ovf    = 1'b0;

    toc_entry_t         toc_q[$];
    disc_result_t       disc_expect_q[$];
    toc_entry_t         offered;
    int                 toc_idx    = 0;
    int                 burst_left = 0;
    int                 gap_left   = 0;
    int                 hold_left  = 0;
    int                 discs_seen = 0;
    bit                 hold_early = 1'b0;
    bit                 hold_late  = 1'b0;
    logic [15:0]        pop_mask   = 16'hFFFF;
    logic [3:0]         pop_phase  = '0;
    int                 idle_count = 0;
    int                 errors     = 0;

    cd_disc_id_generator dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .start_minutes  (start_minutes),
        .start_seconds  (start_seconds),
        .last_track     (last_track),
        .length_minutes (length_minutes),
        .length_seconds (length_seconds),
        .pop            (pop),
        .empty          (empty),
        .disc_id        (disc_id),
        .track_total    (track_total),
        .track_overflow (track_overflow)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", field, got, want, $realtime);
    endtask

    // sum of the decimal digits of a seconds count
    function automatic int unsigned decimal_digit_total(input int unsigned value);
        int unsigned s;
        s = 0;
        while (value != 0)
        begin
            s += value % 10;
            value /= 10;
        end
        return s;
    endfunction

    // fold one accepted track into the running disc, queue the ID on the last one
    task automatic predict_track(input toc_entry_t t);
        int unsigned  start;
        int unsigned  len;
        int unsigned  play;
        disc_result_t r;
        start = t.smin * 60 + t.ssec;
        if (acc_tracks < MAX_TRACK_COUNT)
        begin
            if (acc_tracks == 0)
            begin
                acc_first = start;
            end
            acc_digits += decimal_digit_total(start);
            acc_tracks++;
        end
        else
        begin
            acc_ovf = 1'b1;
        end
        if (t.last)
        begin
            len  = t.lmin * 60 + t.lsec;
            play = (len > acc_first) ? len - acc_first : 0;
            r.id    = {CSUM_W'(acc_digits % CSUM_MOD), PLAY_W'(play), COUNT_W'(acc_tracks)};
            r.total = TRACK_W'(acc_tracks);
            r.ovf   = acc_ovf;
            if (t.fixed)
            begin
                r = '{t.id, t.total, t.ovf};
            end
            disc_expect_q.push_back(r);
            acc_digits = 0;
            acc_tracks = 0;
            acc_first  = 0;
            acc_ovf    = 1'b0;
        end
    endtask

    // random discs: first one overflows with its last two tracks not counted,
    // second stops at the limit
    task automatic build_random_discs();
        int          n;
        int          disc;
        int          added;
        bit          wild;
        toc_entry_t  e;
        added = 0;
        disc  = 0;
        while (added < RANDOM_ITEMS)
        begin
            if (disc == 0)
                n = MAX_TRACK_COUNT + 2;
            else if (disc == 1)
                n = MAX_TRACK_COUNT;
            else if ($urandom_range(0, 11) == 0)
                n = $urandom_range(MAX_TRACK_COUNT - 4, MAX_TRACK_COUNT + 5);
            else
                n = $urandom_range(1, 20);
            for (int k = 0; k < n; k++)
            begin
                wild    = ($urandom_range(0, 3) == 0);
                e       = '0;
                e.smin  = wild ? MIN_W'($urandom_range(0, 127)) : MIN_W'($urandom_range(0, 99));
                e.ssec  = wild ? SEC_W'($urandom_range(0, 63)) : SEC_W'($urandom_range(0, 59));
                e.last  = (k == n - 1);
                e.lmin  = MIN_W'($urandom_range(0, 127));
                e.lsec  = SEC_W'($urandom_range(0, 63));
                toc_q.push_back(e);
            end
            added += n;
            disc++;
        end
    endtask

    // sender: bursts of items with gaps, predictor fed on each accepted item
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_track(offered);
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    push <= 1'b0;
                    gap_left--;
                end
                else if (toc_idx < toc_q.size())
                begin
                    offered = toc_q[toc_idx];
                    toc_idx++;
                    push           <= 1'b1;
                    start_minutes  <= offered.smin;
                    start_seconds  <= offered.ssec;
                    last_track     <= offered.last;
                    length_minutes <= offered.lmin;
                    length_seconds <= offered.lsec;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // receiver: check each accepted result, stall on a rotating mask, long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                discs_seen++;
                if (disc_expect_q.size() == 0)
                begin
                    report_mismatch("unexpected disc_id", disc_id, 32'h0);
                end
                else
                begin
                    disc_result_t want;
                    want = disc_expect_q.pop_front();
                    if (disc_id !== want.id)
                        report_mismatch("disc_id", disc_id, want.id);
                    if (track_total !== want.total)
                        report_mismatch("track_total", 32'(track_total), 32'(want.total));
                    if (track_overflow !== want.ovf)
                        report_mismatch("track_overflow", 32'(track_overflow), 32'(want.ovf));
                end
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if ((!hold_early && discs_seen >= 12) || (!hold_late && discs_seen >= 60))
            begin
                if (discs_seen >= 60)
                    hold_late = 1'b1;
                hold_early = 1'b1;
                hold_left  = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
            begin
                pop <= pop_mask[pop_phase];
                pop_phase++;
                if (pop_phase == 0)
                begin
                    pop_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_count = 0;
            else
                idle_count++;
            if (idle_count >= IDLE_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // stimulus build, reset, drain and verdict
    initial
    begin
        for (int r = 0; r < N_ROWS; r++)
        begin
            for (int k = 0; k < DIRECTED[r].reps; k++)
            begin
                toc_q.push_back('{DIRECTED[r].smin, DIRECTED[r].ssec, DIRECTED[r].last,
                                  DIRECTED[r].lmin, DIRECTED[r].lsec, DIRECTED[r].fixed,
                                  DIRECTED[r].id, DIRECTED[r].total, DIRECTED[r].ovf});
            end
        end
        build_random_discs();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        while (toc_idx < toc_q.size() || push || disc_expect_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
